// ===== rtl/ght_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the handle table.
`default_nettype none
package ght_pkg;

    localparam int SLOT_BITS   = 12;
    localparam int SLOTS       = 1 << SLOT_BITS;
    localparam int HANDLE_BITS = 32;
    localparam int POS_BITS    = SLOT_BITS + 1;
    localparam int GEN_BITS    = HANDLE_BITS - SLOT_BITS;
    localparam int SLOT_W      = HANDLE_BITS + POS_BITS;

    // Position with the top bit set marks a slot that holds no live entry.
    localparam logic [POS_BITS-1:0] POS_INVALID = POS_BITS'(SLOTS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_SPARE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEAD = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // Commands from the controller, one per controller state.
    typedef struct packed {
        logic clear;
        logic load;
        logic fetch;
        logic eval;
        logic move;
        logic retire;
        logic emit;
    } ght_cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic clear_last;
        logic add_full;
        logic remove_live;
        logic out_free;
    } ght_stat_t;

endpackage : ght_pkg
`default_nettype wire

// ===== rtl/ght_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : ght_ram
`default_nettype wire

// ===== rtl/ght_ctrl.sv =====
// Controller state machine of the handle table.
`default_nettype none
module ght_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ght_pkg::ght_stat_t stat,
    output ght_pkg::ght_cmd_t      cmd
);
    import ght_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_EVAL   = 7'b0001000,
        S_MOVE   = 7'b0010000,
        S_RETIRE = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = stat.add_full ? S_DONE : S_FETCH;
                end
            end
            S_FETCH:  state_next = S_EVAL;
            S_EVAL:   state_next = stat.remove_live ? S_MOVE : S_DONE;
            S_MOVE:   state_next = S_RETIRE;
            S_RETIRE: state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.load   = accept;
    assign cmd.fetch  = (state_reg == S_FETCH);
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.move   = (state_reg == S_MOVE);
    assign cmd.retire = (state_reg == S_RETIRE);
    assign cmd.emit   = (state_reg == S_DONE) && stat.out_free;

endmodule : ght_ctrl
`default_nettype wire

// ===== rtl/ght_dp.sv =====
// Datapath of the handle table: slot, free-list and packed memories, counters, result register.
`default_nettype none
module ght_dp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ght_pkg::ght_cmd_t          cmd,
    output ght_pkg::ght_stat_t              stat,
    input  wire logic [1:0]                 in_opcode,
    input  wire logic [ght_pkg::HANDLE_BITS-1:0] in_handle,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [55:0]                     m_tdata,
    output logic [1:0]                      m_tuser
);
    import ght_pkg::*;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);

    // Control state.
    logic [SLOT_BITS-1:0] clr_cnt_reg;
    logic [SLOT_BITS-1:0] live_reg, live_next;
    logic [SLOT_BITS-1:0] head_reg, head_next;
    logic [SLOT_BITS-1:0] tail_reg, tail_next;
    logic                 m_valid_reg;

    // Item and result payload.
    opcode_t              op_reg;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    logic [HANDLE_BITS-1:0] res_handle_reg, res_handle_next;
    logic [SLOT_BITS-1:0] res_idx_reg, res_idx_next;
    status_t              res_status_reg, res_status_next;
    logic [55:0]          m_data_reg;
    logic [1:0]           m_user_reg;

    // Memory ports.
    logic                 slot_we, nf_we, pk_we;
    logic [SLOT_BITS-1:0] slot_waddr, slot_raddr, nf_waddr, nf_raddr, pk_waddr, pk_raddr;
    logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
    logic [SLOT_BITS-1:0] nf_wdata, nf_rdata;
    logic [HANDLE_BITS-1:0] pk_wdata, pk_rdata;

    // Decoded read data.
    logic [HANDLE_BITS-1:0] rd_handle, new_handle;
    logic [POS_BITS-1:0]    rd_pos;
    logic                   hit, is_add;

    ght_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    ght_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_free_ram (
        .clk(aclk), .we(nf_we), .waddr(nf_waddr), .wdata(nf_wdata),
        .raddr(nf_raddr), .rdata(nf_rdata)
    );

    ght_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_pack_ram (
        .clk(aclk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
        .raddr(pk_raddr), .rdata(pk_rdata)
    );

    assign is_add    = (op_reg == OP_ADD);
    assign rd_handle = slot_rdata[SLOT_W-1:POS_BITS];
    assign rd_pos    = slot_rdata[POS_BITS-1:0];
    assign hit       = (rd_handle == h_reg) && !rd_pos[POS_BITS-1];

    // Advance the generation; on overflow it restarts at zero.
    assign new_handle = (&rd_handle[HANDLE_BITS-1:SLOT_BITS])
                      ? {{GEN_BITS{1'b0}}, rd_handle[SLOT_BITS-1:0]}
                      : {rd_handle[HANDLE_BITS-1:SLOT_BITS] + GEN_BITS'(1),
                         rd_handle[SLOT_BITS-1:0]};

    assign slot_raddr = is_add ? head_reg : h_reg[SLOT_BITS-1:0];
    assign nf_raddr   = head_reg;
    assign pk_raddr   = live_reg - SLOT_BITS'(1);

    assign stat.clear_last  = (clr_cnt_reg == SLOT_LAST);
    assign stat.add_full    = (opcode_t'(in_opcode) == OP_ADD) && (live_reg == SLOT_LAST);
    assign stat.remove_live = (op_reg == OP_REMOVE) && hit;
    assign stat.out_free    = !m_valid_reg || m_tready;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = h_reg[SLOT_BITS-1:0];
        slot_wdata = {h_reg, POS_INVALID};
        nf_we      = 1'b0;
        nf_waddr   = tail_reg;
        nf_wdata   = h_reg[SLOT_BITS-1:0];
        pk_we      = 1'b0;
        pk_waddr   = pos_reg;
        pk_wdata   = pk_rdata;
        live_next  = live_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        pos_next   = pos_reg;
        res_handle_next = res_handle_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;

        if (cmd.clear) begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg;
            slot_wdata = {{GEN_BITS{1'b0}}, clr_cnt_reg, POS_INVALID};
            nf_we      = 1'b1;
            nf_waddr   = clr_cnt_reg;
            nf_wdata   = clr_cnt_reg + SLOT_BITS'(1);
        end

        if (cmd.load && stat.add_full) begin
            res_handle_next = '0;
            res_idx_next    = '0;
            res_status_next = ST_FULL;
        end

        if (cmd.eval) begin
            if (is_add) begin
                slot_we    = 1'b1;
                slot_waddr = head_reg;
                slot_wdata = {new_handle, 1'b0, live_reg};
                pk_we      = 1'b1;
                pk_waddr   = live_reg;
                pk_wdata   = new_handle;
                head_next  = nf_rdata;
                live_next  = live_reg + SLOT_BITS'(1);
                res_handle_next = new_handle;
                res_idx_next    = live_reg;
                res_status_next = ST_OK;
            end else if (!hit) begin
                res_handle_next = h_reg;
                res_idx_next    = '0;
                res_status_next = ST_DEAD;
            end else if (op_reg == OP_REMOVE) begin
                pos_next  = rd_pos[SLOT_BITS-1:0];
                live_next = live_reg - SLOT_BITS'(1);
            end else begin
                res_handle_next = h_reg;
                res_idx_next    = rd_pos[SLOT_BITS-1:0];
                res_status_next = ST_OK;
            end
        end

        if (cmd.move) begin
            // The last packed entry fills the hole and its slot is repointed.
            pk_we      = 1'b1;
            slot_we    = 1'b1;
            slot_waddr = pk_rdata[SLOT_BITS-1:0];
            slot_wdata = {pk_rdata, 1'b0, pos_reg};
        end

        if (cmd.retire) begin
            slot_we   = 1'b1;
            nf_we     = 1'b1;
            tail_next = h_reg[SLOT_BITS-1:0];
            res_handle_next = h_reg;
            res_idx_next    = pos_reg;
            res_status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            live_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= SLOT_LAST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_BITS'(1);
            end
            live_reg <= live_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= opcode_t'(in_opcode);
            h_reg  <= in_handle;
        end
        pos_reg        <= pos_next;
        res_handle_reg <= res_handle_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        if (cmd.emit) begin
            m_data_reg <= {live_reg, res_idx_reg, res_handle_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule : ght_dp
`default_nettype wire

// ===== rtl/generational_handle_table_unit.sv =====
// Top level of the generational handle table: controller, datapath and checks.
//
//  Channel  Direction  tdata (low bit up)                          tuser
//  s_       in         handle[31:0]                                opcode[1:0]
//  m_       out        result_handle[31:0], dense_index[43:32],    status[1:0]
//                      live_total[55:44]
//
// After reset the block initializes the slot and free-list memories, one entry
// per cycle, with s_tready low. Each operation is then carried out one at a
// time. An add, a lookup or a dead-handle operation passes through the fetch
// and eval states, a remove of a live handle also through move and retire, set
// by the chain of registered reads and writes through the slot and packed
// memories; an add on a full table goes straight to the done state. s_tready
// returns once the result has been loaded into the output register.
// A finished result waits in the output register while the next transaction
// is accepted and processed; that next result holds until m_tready frees it.
`default_nettype none
module generational_handle_table_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // handle[31:0]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // result_handle[31:0], dense_index[43:32], live_total[55:44]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import ght_pkg::*;

    ght_cmd_t  cmd;
    ght_stat_t stat;

    // The controller sequences each transaction; it sees only the handshake and status.
    ght_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns all memories, the live count, the free-list pointers and
    // the result register.
    ght_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_opcode (s_tuser),
        .in_handle (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A table-full result carries a zero handle and index and a full live count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |->
            (m_tdata[31:0] == '0) && (m_tdata[43:32] == '0) && (&m_tdata[55:44]))
        else $error("full result with bad payload");

    // A dead-handle result always reports dense index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DEAD) |-> (m_tdata[43:32] == '0))
        else $error("dead handle result with nonzero index");

    // No transaction is accepted during the initialization sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_tready)
        else $error("input ready during initialization");

    // Operations are processed one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted back to back");

endmodule : generational_handle_table_unit
`default_nettype wire
